// File: hdl/ldpq_pkg.sv
// ----------------------------------------------------------------------------
// ldpq_pkg
// Shared constants, types and codes for the link delay packet queue.
// ----------------------------------------------------------------------------
package ldpq_pkg;

    // Sizing
    localparam int RING_ENTRIES          = 64;
    localparam int MAX_PACKET_BYTES      = 1024;
    localparam int HEADER_OVERHEAD_BYTES = 28;
    localparam int TICKS_PER_SECOND      = 1000;

    // Fixed field widths
    localparam int TIME_W    = 32;
    localparam int LEN_W     = 16;
    localparam int TAG_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int FREE_W    = 6;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;

    // Derived widths
    localparam int IDX_W = $clog2(RING_ENTRIES);
    localparam int CNT_PTR_W = IDX_W + 1;
    localparam int BYTES_W = $clog2(MAX_PACKET_BYTES + HEADER_OVERHEAD_BYTES + 1);
    localparam longint unsigned MAX_PRODUCT =
        (longint'(MAX_PACKET_BYTES) + longint'(HEADER_OVERHEAD_BYTES)) *
        longint'(TICKS_PER_SECOND);
    localparam int DVD_W = $clog2(MAX_PRODUCT + 1);
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT   = 1'd1;
    localparam logic [CFG_W-1:0] LINK_RATE_RESET = 20'd2000;
    localparam logic [CFG_W-1:0] TRANSIT_RESET   = 20'd50;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOT_YET  = 3'd4,
        ST_DROPPED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DIV,
        S_WRITE,
        S_DONE
    } ldpq_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] entry_end;
        logic [TIME_W-1:0] exit_at;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  tag;
    } ldpq_entry_t;

endpackage

// File: hdl/ldpq_req_if.sv
// ----------------------------------------------------------------------------
// ldpq_req_if
// Request channel: put or get word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ldpq_req_if;
    import ldpq_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] current_time;
    logic [LEN_W-1:0]  packet_length;
    logic [TAG_W-1:0]  packet_tag;
    logic [LEN_W-1:0]  buffer_capacity;

    modport source (
        output valid, op, current_time, packet_length, packet_tag, buffer_capacity,
        input  ready
    );

    modport sink (
        input  valid, op, current_time, packet_length, packet_tag, buffer_capacity,
        output ready
    );

endinterface

// File: hdl/ldpq_rsp_if.sv
// ----------------------------------------------------------------------------
// ldpq_rsp_if
// Response channel: one result word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ldpq_rsp_if;
    import ldpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    delivered_length;
    logic [TAG_W-1:0]    delivered_tag;
    logic [FREE_W-1:0]   free_slots;

    modport source (
        output valid, status, delivered_length, delivered_tag, free_slots,
        input  ready
    );

    modport sink (
        input  valid, status, delivered_length, delivered_tag, free_slots,
        output ready
    );

endinterface

// File: hdl/link_delay_packet_queue_unit.sv
// ----------------------------------------------------------------------------
// link_delay_packet_queue_unit
// Emulates a slow link as a ring of packet descriptors. A put stamps the
// packet with its serialization end and exit time; a get pops the head once
// its exit time has passed. Takes one request word at a time: a get or a
// rejected put passes through the read, check and done states to the result,
// and an accepted put with a nonzero link rate also runs the bit-serial
// restoring divider that turns the byte count into ticks, one quotient bit
// per cycle, before the write state. With a zero rate a put skips the divider.
// The result sits in an output register, so a new request is taken while a
// result is still waiting. Descriptor storage is a single-port RAM with a
// registered read; entries are never cleared, so there is no init pass.
// ----------------------------------------------------------------------------
module link_delay_packet_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    ldpq_req_if.sink                      req,
    ldpq_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [ldpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldpq_pkg::CFG_W-1:0]     cfg_data
);
    import ldpq_pkg::*;

    // Control state
    ldpq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]     rate_reg, transit_reg;

    // Captured request word
    logic              op_reg, op_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;

    // Working registers
    logic [TIME_W-1:0] start_reg, start_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    status_t           res_status_reg, res_status_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic [TAG_W-1:0]  res_tag_reg, res_tag_next;

    // Output register
    status_t           out_status_reg, out_status_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic [FREE_W-1:0] out_free_reg, out_free_next;

    // Descriptor RAM
    ldpq_entry_t       mem [RING_ENTRIES];
    ldpq_entry_t       rd_q_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    ldpq_entry_t       mem_wdata;

    // Helpers
    logic [IDX_W-1:0]     head_inc, tail_inc, tail_dec;
    logic                 ring_empty, ring_full;
    logic [CNT_PTR_W-1:0] used;
    logic [CNT_PTR_W-1:0] free_cnt;
    logic [TIME_W-1:0]    prev_diff, exit_diff;
    logic [BYTES_W-1:0]   bytes;
    logic [DVD_W-1:0]     product;
    logic [CFG_W:0]       rem_shift;
    logic [CFG_W:0]       rem_sub;
    logic                 rem_ge;
    logic [TIME_W-1:0]    end_time;

    assign head_inc = (head_reg == IDX_W'(RING_ENTRIES - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(RING_ENTRIES - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_W'(RING_ENTRIES - 1) : tail_reg - 1'b1;
    assign ring_empty = (head_reg == tail_reg);
    assign ring_full  = (tail_inc == head_reg);

    always_comb
    begin
        if (tail_reg >= head_reg)
            used = CNT_PTR_W'(tail_reg) - CNT_PTR_W'(head_reg);
        else
            used = CNT_PTR_W'(tail_reg) + CNT_PTR_W'(RING_ENTRIES) - CNT_PTR_W'(head_reg);
        free_cnt = CNT_PTR_W'(RING_ENTRIES - 1) - used;
    end

    assign rd_addr   = op_reg ? head_reg : tail_dec;
    assign prev_diff = rd_q_reg.entry_end - now_reg;
    assign exit_diff = rd_q_reg.exit_at - now_reg;

    // len is already checked against the limit, so the sum fits
    assign bytes   = BYTES_W'(len_reg) + BYTES_W'(HEADER_OVERHEAD_BYTES);
    assign product = DVD_W'(bytes) * DVD_W'(TICKS_PER_SECOND);

    // Restoring divide step: quotient bits shift into dvd_reg from the bottom
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, rate_reg});
    assign rem_sub   = rem_shift - {1'b0, rate_reg};

    assign end_time  = start_reg + TIME_W'(dvd_reg);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        len_next        = len_reg;
        tag_next        = tag_reg;
        cap_next        = cap_reg;
        start_next      = start_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_len_next    = res_len_reg;
        res_tag_next    = res_tag_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_tag_next    = out_tag_reg;
        out_free_next   = out_free_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_wdata       = '{entry_end: end_time,
                            exit_at:   end_time + TIME_W'(transit_reg),
                            length:    len_reg,
                            tag:       tag_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    now_next   = req.current_time;
                    len_next   = req.packet_length;
                    tag_next   = req.packet_tag;
                    cap_next   = req.buffer_capacity;
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                res_len_next = '0;
                res_tag_next = '0;
                state_next   = S_DONE;
                if (!op_reg)
                begin
                    if (ring_full)
                        res_status_next = ST_FULL;
                    else if (len_reg > LEN_W'(MAX_PACKET_BYTES))
                        res_status_next = ST_TOO_LONG;
                    else
                    begin
                        // start after the prior packet if its entry end is still ahead
                        if (!ring_empty && prev_diff != '0 && !prev_diff[TIME_W-1])
                            start_next = rd_q_reg.entry_end;
                        else
                            start_next = now_reg;
                        rem_next = '0;
                        if (rate_reg == '0)
                        begin
                            dvd_next   = '0;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            dvd_next   = product;
                            cnt_next   = DIV_CNT_W'(DVD_W);
                            state_next = S_DIV;
                        end
                    end
                end
                else
                begin
                    if (ring_empty)
                        res_status_next = ST_EMPTY;
                    else if (!exit_diff[TIME_W-1])
                        res_status_next = ST_NOT_YET;
                    else
                    begin
                        head_next = head_inc;
                        if (cap_reg < rd_q_reg.length)
                            res_status_next = ST_DROPPED;
                        else
                        begin
                            res_status_next = ST_OK;
                            res_len_next    = rd_q_reg.length;
                            res_tag_next    = rd_q_reg.tag;
                        end
                    end
                end
            end

            S_DIV:
            begin
                rem_next = rem_ge ? rem_sub[CFG_W-1:0] : rem_shift[CFG_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                    state_next = S_WRITE;
            end

            S_WRITE:
            begin
                mem_we          = 1'b1;
                tail_next       = tail_inc;
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_len_next    = res_len_reg;
                    out_tag_next    = res_tag_reg;
                    out_free_next   = FREE_W'(free_cnt);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= LINK_RATE_RESET;
            transit_reg <= TRANSIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINK_RATE: rate_reg    <= cfg_data;
                CFG_TRANSIT:   transit_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        len_reg        <= len_next;
        tag_reg        <= tag_next;
        cap_reg        <= cap_next;
        start_reg      <= start_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_len_reg    <= res_len_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_tag_reg    <= out_tag_next;
        out_free_reg   <= out_free_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= mem_wdata;
        if (state_reg == S_READ)
            rd_q_reg <= mem[rd_addr];
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.delivered_length = out_len_reg;
    assign rsp.delivered_tag    = out_tag_reg;
    assign rsp.free_slots       = out_free_reg;

endmodule
